>>> sv/ramdac_palette_host_interface_core_assert.svh
// Assertion macros used by the RAMDAC host interface checker
`ifndef RAMDAC_PALETTE_HOST_INTERFACE_CORE_ASSERT_SVH
`define RAMDAC_PALETTE_HOST_INTERFACE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RPHI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RPHI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rphi_pkg.sv
// Shared types and constants of the RAMDAC palette host interface
`default_nettype none

package rphi_pkg;

    localparam int DATA_W = 8;

    typedef enum logic [2:0] {
        OFF_ADDR_WR     = 3'd0,
        OFF_PALETTE     = 3'd1,
        OFF_PIXEL_MASK  = 3'd2,
        OFF_ADDR_RD     = 3'd3,
        OFF_OVL_ADDR_WR = 3'd4,
        OFF_OVERLAY     = 3'd5,
        OFF_COMMAND     = 3'd6,
        OFF_OVL_ADDR_RD = 3'd7
    } reg_offset_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_HOLD,
        SRC_PALETTE,
        SRC_OVERLAY
    } rd_src_t;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } phase_t;

    typedef logic [1:0] comp_t;

    localparam comp_t COMP_RED   = 2'd0;
    localparam comp_t COMP_GREEN = 2'd1;
    localparam comp_t COMP_BLUE  = 2'd2;
    localparam comp_t COMP_BAD   = 2'd3;

    // config register select, taken from paddr[2]
    localparam logic CFG_OVERLAY_ENABLE = 1'b0;
    localparam logic CFG_COMMAND_ENABLE = 1'b1;

    typedef struct packed {
        logic              valid;
        rd_src_t           src;
        logic [DATA_W-1:0] byte_val;
    } stage_t;

endpackage

`default_nettype wire

>>> sv/ramdac_palette_host_interface_core.sv
// Top level of the RAMDAC palette host interface: decode, counters and color memories
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_stall    | req_type, reg_offset, write_data
//  out      | out_valid / out_stall  | read_data
//  config   | APB psel/penable       | paddr, pwdata, prdata, pready
//
//  One transaction per cycle while in_stall is low; read_data passes the
//  memory read register (with the read stage), then the output register.
//  After reset a clearing pass zeroes the color memories with in_stall
//  high; config writes are taken throughout.
//  With out_stall high the output register holds, one more transaction
//  waits in the read stage, then in_stall rises.
`default_nettype none

module ramdac_palette_host_interface_core
    import rphi_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int OVERLAY_ENTRIES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              req_type,
    input  wire logic [2:0]        reg_offset,
    input  wire logic [DATA_W-1:0] write_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [DATA_W-1:0] read_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int PAL_DEPTH = 3 * PALETTE_ENTRIES;
    localparam int PAL_IDX_W = $clog2(PAL_DEPTH);
    localparam int OVL_DEPTH = 3 * OVERLAY_ENTRIES;
    localparam int OVL_IDX_W = $clog2(OVL_DEPTH);

    logic              overlay_enable_reg;
    logic              command_enable_reg;
    logic [DATA_W-1:0] address_reg;
    comp_t             comp_reg;
    logic [DATA_W-1:0] pixel_mask_reg;
    logic [DATA_W-1:0] command_byte_reg;
    stage_t            s1_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;

    logic              clr_busy;
    logic [PAL_IDX_W-1:0] clr_addr;

    logic              accept;
    logic              s1_move;
    logic              cfg_wr;
    reg_offset_t       off;
    logic              is_addr;
    logic              is_pal;
    logic              is_ovl;
    logic              is_mask;
    logic              is_cmd;
    comp_t             comp_sel;
    comp_t             comp_adv;
    logic              comp_wrap;
    logic [PAL_IDX_W-1:0] pal_entry;
    logic [PAL_IDX_W-1:0] pal_slot;
    logic [OVL_IDX_W-1:0] ovl_entry;
    logic [OVL_IDX_W-1:0] ovl_slot;
    rd_src_t           src_new;
    logic [DATA_W-1:0] hold_new;
    logic [DATA_W-1:0] out_new;

    logic                 pal_we;
    logic [PAL_IDX_W-1:0] pal_waddr;
    logic [DATA_W-1:0]    pal_wdata;
    logic                 pal_re;
    logic [DATA_W-1:0]    pal_rdata;
    logic                 ovl_we;
    logic [OVL_IDX_W-1:0] ovl_waddr;
    logic [DATA_W-1:0]    ovl_wdata;
    logic                 ovl_re;
    logic [DATA_W-1:0]    ovl_rdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == CFG_COMMAND_ENABLE) ? {31'b0, command_enable_reg}
                                                     : {31'b0, overlay_enable_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_enable_reg <= 1'b1;
            command_enable_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_OVERLAY_ENABLE)
            begin
                overlay_enable_reg <= pwdata[0];
            end
            else
            begin
                command_enable_reg <= pwdata[0];
            end
        end
    end

    // clearing pass
    rphi_clear #(
        .DEPTH (PAL_DEPTH)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    // handshake
    assign s1_move  = s1_reg.valid && (!out_valid_reg || !out_stall);
    assign in_stall = clr_busy || (s1_reg.valid && !s1_move);
    assign accept   = in_valid && !in_stall;

    // offset decode
    always_comb
    begin
        off     = reg_offset_t'(reg_offset);
        is_addr = 1'b0;
        is_pal  = 1'b0;
        is_ovl  = 1'b0;
        is_mask = 1'b0;
        is_cmd  = 1'b0;
        unique case (off)
            OFF_ADDR_WR, OFF_ADDR_RD:         is_addr = 1'b1;
            OFF_OVL_ADDR_WR, OFF_OVL_ADDR_RD: is_addr = overlay_enable_reg;
            OFF_PALETTE:                      is_pal  = 1'b1;
            OFF_PIXEL_MASK:                   is_mask = 1'b1;
            OFF_OVERLAY:                      is_ovl  = overlay_enable_reg;
            OFF_COMMAND:                      is_cmd  = command_enable_reg;
            default:                          is_addr = 1'b0;
        endcase
    end

    // component counter
    always_comb
    begin
        comp_sel  = (comp_reg == COMP_BAD) ? COMP_RED : comp_reg;
        comp_wrap = 1'b0;
        unique case (comp_reg)
            COMP_RED:   comp_adv = COMP_GREEN;
            COMP_GREEN: comp_adv = COMP_BLUE;
            COMP_BLUE:
            begin
                comp_adv  = COMP_RED;
                comp_wrap = 1'b1;
            end
            COMP_BAD:   comp_adv = COMP_GREEN;
            default:    comp_adv = COMP_RED;
        endcase
    end

    // memory slots
    assign pal_entry = PAL_IDX_W'(32'(address_reg) % PALETTE_ENTRIES);
    assign pal_slot  = (pal_entry << 1) + pal_entry + PAL_IDX_W'(comp_sel);
    assign ovl_entry = OVL_IDX_W'(32'(address_reg) % OVERLAY_ENTRIES);
    assign ovl_slot  = (ovl_entry << 1) + ovl_entry + OVL_IDX_W'(comp_sel);

    assign pal_we    = clr_busy || (accept && is_pal && req_type);
    assign pal_waddr = clr_busy ? clr_addr : pal_slot;
    assign pal_wdata = clr_busy ? '0 : write_data;
    assign pal_re    = accept && is_pal && !req_type;

    assign ovl_we    = clr_busy ? (clr_addr < PAL_IDX_W'(OVL_DEPTH))
                                : (accept && is_ovl && req_type);
    assign ovl_waddr = clr_busy ? OVL_IDX_W'(clr_addr) : ovl_slot;
    assign ovl_wdata = clr_busy ? '0 : write_data;
    assign ovl_re    = accept && is_ovl && !req_type;

    rphi_ram #(
        .DEPTH (PAL_DEPTH),
        .WIDTH (DATA_W)
    ) u_palette_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_slot),
        .rdata (pal_rdata)
    );

    rphi_ram #(
        .DEPTH (OVL_DEPTH),
        .WIDTH (DATA_W)
    ) u_overlay_ram (
        .clk   (clk),
        .we    (ovl_we),
        .waddr (ovl_waddr),
        .wdata (ovl_wdata),
        .re    (ovl_re),
        .raddr (ovl_slot),
        .rdata (ovl_rdata)
    );

    // host registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg      <= '0;
            comp_reg         <= COMP_RED;
            pixel_mask_reg   <= '0;
            command_byte_reg <= '0;
        end
        else if (accept)
        begin
            if (is_addr)
            begin
                comp_reg <= COMP_RED;
                if (req_type)
                begin
                    address_reg <= write_data;
                end
            end
            if (is_pal || is_ovl)
            begin
                comp_reg <= comp_adv;
                if (comp_wrap)
                begin
                    address_reg <= address_reg + DATA_W'(1);
                end
            end
            if (is_mask && req_type)
            begin
                pixel_mask_reg <= write_data;
            end
            if (is_cmd && req_type)
            begin
                command_byte_reg <= write_data;
            end
        end
    end

    // read stage
    always_comb
    begin
        priority if (req_type)
        begin
            src_new = SRC_ZERO;
        end
        else if (is_pal)
        begin
            src_new = SRC_PALETTE;
        end
        else if (is_ovl)
        begin
            src_new = SRC_OVERLAY;
        end
        else if (is_addr || is_mask || is_cmd)
        begin
            src_new = SRC_HOLD;
        end
        else
        begin
            src_new = SRC_ZERO;
        end

        priority if (is_addr)
        begin
            hold_new = address_reg;
        end
        else if (is_mask)
        begin
            hold_new = pixel_mask_reg;
        end
        else
        begin
            hold_new = command_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (accept)
        begin
            s1_reg.valid    <= 1'b1;
            s1_reg.src      <= src_new;
            s1_reg.byte_val <= hold_new;
        end
        else if (s1_move)
        begin
            s1_reg.valid <= 1'b0;
        end
    end

    // output register
    always_comb
    begin
        unique case (s1_reg.src)
            SRC_ZERO:    out_new = '0;
            SRC_HOLD:    out_new = s1_reg.byte_val;
            SRC_PALETTE: out_new = pal_rdata;
            SRC_OVERLAY: out_new = ovl_rdata;
            default:     out_new = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            read_data_reg <= out_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

`default_nettype wire

>>> sv/rphi_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data
`default_nettype none

module rphi_ram #(
    parameter int DEPTH = 768,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/rphi_clear.sv
// Post-reset clearing sequencer that sweeps the color memories to zero
`default_nettype none

module rphi_clear
    import rphi_pkg::*;
#(
    parameter int DEPTH = 768
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    output logic                          busy,
    output logic [$clog2(DEPTH)-1:0]      addr
);

    localparam int CNT_W = $clog2(DEPTH);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              last;

    assign last = (cnt_reg == CNT_W'(DEPTH - 1));

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_CLEAR:
            begin
                if (last)
                begin
                    phase_next = PH_RUN;
                end
            end
            PH_RUN:
            begin
                phase_next = PH_RUN;
            end
            default:
            begin
                phase_next = PH_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        cnt_next = cnt_reg;
        unique case (phase_reg)
            PH_CLEAR:
            begin
                busy     = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            PH_RUN:
            begin
                busy = 1'b0;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign addr = cnt_reg;

endmodule

`default_nettype wire

>>> sv/rphi_checker.sv
// Port-level checker for the RAMDAC host interface, bound to the top level
`default_nettype none

`include "ramdac_palette_host_interface_core_assert.svh"

module rphi_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] read_data,
    input wire logic       pready
);

    // every accepted transaction shows up at the output
    `RPHI_ASSERT_IMP(a_latency, in_valid && !in_stall, ##2 out_valid, "result missing")

    // no result without an earlier accepted transaction
    `RPHI_ASSERT_IMP(a_no_phantom, $rose(out_valid), $past(in_valid && !in_stall, 2), "phantom result")

    `RPHI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data), "result dropped")

    `RPHI_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")

endmodule

bind ramdac_palette_host_interface_core rphi_checker u_rphi_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RAMDAC palette host interface core

module testbench
    import rphi_pkg::*;
();

    localparam int PALETTE_ENTRIES = 256;
    localparam int OVERLAY_ENTRIES = 16;
    localparam bit REQ_READ = 1'b0;
    localparam bit REQ_WRITE = 1'b1;

    class palette_scoreboard;
        bit          overlay_en;
        bit          command_en;
        bit [7:0]    address;
        int unsigned component;
        bit [7:0]    palette [3*PALETTE_ENTRIES];
        bit [7:0]    overlay [3*OVERLAY_ENTRIES];
        bit [7:0]    pixel_mask;
        bit [7:0]    command_byte;
        bit [7:0]    expected_bytes [$];
        int          mismatches;
        int          results_checked;
        int          accesses;

        function new();
            overlay_en = 1'b1;
            command_en = 1'b1;
        endfunction

        function bit is_live(reg_offset_t off);
            case (off)
                OFF_OVL_ADDR_WR, OFF_OVERLAY, OFF_OVL_ADDR_RD: return overlay_en;
                OFF_COMMAND: return command_en;
                default: return 1'b1;
            endcase
        endfunction

        function void advance();
            component = (component + 1) % 3;
            if (component == 0)
                address = address + 8'd1;
        endfunction

        function void note_access(bit wr, reg_offset_t off, bit [7:0] data);
            bit [7:0] rd;
            int       slot;
            rd = '0;
            accesses++;
            slot = (component < 3) ? component : 0;
            case (off)
                OFF_ADDR_WR, OFF_ADDR_RD, OFF_OVL_ADDR_WR, OFF_OVL_ADDR_RD:
                begin
                    if (is_live(off))
                    begin
                        component = 0;
                        if (wr)
                            address = data;
                        else
                            rd = address;
                    end
                end
                OFF_PALETTE:
                begin
                    slot += (address % PALETTE_ENTRIES) * 3;
                    if (wr)
                        palette[slot] = data;
                    else
                        rd = palette[slot];
                    advance();
                end
                OFF_PIXEL_MASK:
                begin
                    if (wr)
                        pixel_mask = data;
                    else
                        rd = pixel_mask;
                end
                OFF_OVERLAY:
                begin
                    if (overlay_en)
                    begin
                        slot += (address % OVERLAY_ENTRIES) * 3;
                        if (wr)
                            overlay[slot] = data;
                        else
                            rd = overlay[slot];
                        advance();
                    end
                end
                default:
                begin
                    if (command_en)
                    begin
                        if (wr)
                            command_byte = data;
                        else
                            rd = command_byte;
                    end
                end
            endcase
            expected_bytes.push_back(wr ? 8'd0 : rd);
        endfunction

        function void check_read_data(logic [7:0] actual);
            bit [7:0] want;
            if (expected_bytes.size() == 0)
            begin
                $error("read_data: unexpected transaction, actual %0h", actual);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                results_checked++;
                if (actual !== want)
                begin
                    $error("read_data: expected %0h actual %0h", want, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_READ;
    reg_offset_t reg_offset = OFF_ADDR_WR;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    palette_scoreboard sb = new();
    int burst_left = 0;
    int live_items = 0;
    logic [7:0] stall_tick = '0;
    int stall_mode = 0;

    ramdac_palette_host_interface_core #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES),
        .OVERLAY_ENTRIES(OVERLAY_ENTRIES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .reg_offset(reg_offset),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick[5:0] == 6'd0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= (stall_tick[3:0] < 4'd10);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_read_data(read_data);
    end

    task automatic send(bit wr, reg_offset_t off, bit [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= wr;
        reg_offset <= off;
        write_data <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (sb.is_live(off))
            live_items++;
        sb.note_access(wr, off, data);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_enable(logic sel, bit value);
        drain();
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= ($urandom() & 32'hFFFF_FFFE) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == CFG_OVERLAY_ENABLE)
            sb.overlay_en = value;
        else
            sb.command_en = value;
    endtask

    function automatic reg_offset_t pick_addr_offset();
        reg_offset_t choices [4] = '{OFF_ADDR_WR, OFF_ADDR_RD, OFF_OVL_ADDR_WR, OFF_OVL_ADDR_RD};
        return choices[$urandom_range(0, sb.overlay_en ? 3 : 1)];
    endfunction

    // load a run of components, then reload the address and read them back
    task automatic fill_and_readback(reg_offset_t data_off);
        bit [7:0] start;
        int       n;
        start = 8'($urandom_range(0, 255));
        n = $urandom_range(1, 36);
        send(REQ_WRITE, pick_addr_offset(), start);
        repeat (n) send(REQ_WRITE, data_off, 8'($urandom_range(0, 255)));
        send(REQ_WRITE, pick_addr_offset(), start);
        repeat (n) send(REQ_READ, data_off, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1))
            send(REQ_READ, pick_addr_offset(), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(int target);
        int stop;
        int kind;
        stop = live_items + target;
        while (live_items < stop)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
                fill_and_readback(OFF_PALETTE);
            else if (kind <= 5)
                fill_and_readback(sb.overlay_en ? OFF_OVERLAY : OFF_PALETTE);
            else if (kind == 6)
            begin
                send(REQ_WRITE, OFF_PIXEL_MASK, 8'($urandom_range(0, 255)));
                send(REQ_READ, OFF_PIXEL_MASK, 8'($urandom_range(0, 255)));
                send(REQ_WRITE, OFF_COMMAND, 8'($urandom_range(0, 255)));
                send(REQ_READ, OFF_COMMAND, 8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send(($urandom_range(0, 1) == 1), reg_offset_t'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        int cycles;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared memories and registers after reset
        send(REQ_READ, OFF_ADDR_WR, 8'hFF);
        send(REQ_READ, OFF_PALETTE, 8'h00);
        send(REQ_READ, OFF_ADDR_RD, 8'h5A);
        send(REQ_READ, OFF_PIXEL_MASK, 8'h00);
        send(REQ_READ, OFF_COMMAND, 8'h00);
        send(REQ_WRITE, OFF_PIXEL_MASK, 8'hFF);
        send(REQ_READ, OFF_PIXEL_MASK, 8'h00);
        send(REQ_WRITE, OFF_COMMAND, 8'hA5);
        send(REQ_READ, OFF_COMMAND, 8'hFF);
        // address wraps from 255 to 0 after the third component
        send(REQ_WRITE, OFF_ADDR_WR, 8'hFF);
        send(REQ_WRITE, OFF_PALETTE, 8'h00);
        send(REQ_WRITE, OFF_PALETTE, 8'hFF);
        send(REQ_WRITE, OFF_PALETTE, 8'h80);
        send(REQ_READ, OFF_ADDR_RD, 8'h00);
        // overlay entry selected by address mod 16
        send(REQ_WRITE, OFF_OVL_ADDR_WR, 8'h1F);
        send(REQ_WRITE, OFF_OVERLAY, 8'h11);
        send(REQ_WRITE, OFF_OVERLAY, 8'h22);
        send(REQ_WRITE, OFF_OVERLAY, 8'h33);
        send(REQ_READ, OFF_OVL_ADDR_RD, 8'h00);
        send(REQ_WRITE, OFF_OVL_ADDR_RD, 8'h2F);
        send(REQ_READ, OFF_OVERLAY, 8'h00);
        // address access mid-entry restarts at the first component
        send(REQ_WRITE, OFF_ADDR_RD, 8'hFF);
        send(REQ_READ, OFF_PALETTE, 8'h00);
        send(REQ_READ, OFF_ADDR_WR, 8'h00);
        send(REQ_READ, OFF_PALETTE, 8'h00);
        send(REQ_WRITE, OFF_PIXEL_MASK, 8'h00);
        drain();

        run_phase(300);
        write_enable(CFG_OVERLAY_ENABLE, 1'b0);
        write_enable(CFG_COMMAND_ENABLE, 1'b0);
        run_phase(300);
        write_enable(CFG_OVERLAY_ENABLE, 1'b1);
        run_phase(300);
        write_enable(CFG_OVERLAY_ENABLE, 1'b0);
        write_enable(CFG_COMMAND_ENABLE, 1'b1);
        run_phase(300);
        write_enable(CFG_OVERLAY_ENABLE, 1'b1);
        run_phase(300);

        in_valid <= 1'b0;
        cycles = 0;
        while (sb.expected_bytes.size() != 0 && cycles < 20000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (8) @(posedge clk);
        if (sb.expected_bytes.size() != 0)
        begin
            $error("read_data: %0d transactions never returned", sb.expected_bytes.size());
            sb.mismatches++;
        end

        $display("Ran %0d host accesses with %0d results checked,", sb.accesses,
                 sb.results_checked);
        $display("across all four overlay/command enable combinations.");
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
